// ===== design/bsa_pkg.sv =====
// shared types and constants for the bitmap slot allocator
`default_nettype none

package bsa_pkg;

  // field widths
  localparam int SLOT_W   = 10;
  localparam int CFG_W    = 11;
  localparam int STATUS_W = 3;

  // bitmap word geometry
  localparam int WORD_W     = 64;
  localparam int BIT_IDX_W  = 6;
  localparam int WORD_SEL_W = CFG_W - BIT_IDX_W;

  // request codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ROOT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

  // reset value of the slot limit register
  localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = 11'd1024;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACCESS
  } state_t;

  // find-first result
  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] index;
  } ff_result_t;

endpackage

`default_nettype wire

// ===== design/bitmap_slot_allocator.sv =====
// first-fit slot allocator over an occupancy bitmap held in 64-bit words
`default_nettype none

// Requests are taken when start is high and busy is low; each gives exactly one
// result, shown for one cycle with done high, and the receiver cannot stall it.
// Free and check requests read the word holding the slot and finish in the access state. An
// allocate request walks the bitmap one 64-bit word per cycle through a single find-first
// unit, reading words until a free slot is found, at most ceil(limit / 64) of them,
// sixteen at the default limit.
// The occupancy words carry valid bits that reset clears, so no clearing pass is
// needed. The slot limit is active_slots saturated to SLOT_COUNT; write
// active_slots only while busy is low.
module bitmap_slot_allocator #(
  parameter int SLOT_COUNT = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic [1:0]                     op,
  input  wire logic [bsa_pkg::SLOT_W-1:0]     slot_index,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bsa_pkg::CFG_W-1:0]      cfg_data,
  output      logic                           done,
  output      logic [bsa_pkg::SLOT_W-1:0]     granted_slot,
  output      logic [bsa_pkg::STATUS_W-1:0]   status,
  output      logic [bsa_pkg::CFG_W-1:0]      live_count
);

  // highest reachable limit: the register is 11 bits wide
  localparam int LIM_CAP   = (SLOT_COUNT < 2047) ? SLOT_COUNT : 2047;
  localparam int NUM_WORDS = (LIM_CAP + bsa_pkg::WORD_W - 1) / bsa_pkg::WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [bsa_pkg::CFG_W-1:0] CAP = bsa_pkg::CFG_W'(LIM_CAP);

  bsa_pkg::state_t state, state_next;

  logic [bsa_pkg::CFG_W-1:0]    active_slots;
  logic [bsa_pkg::CFG_W-1:0]    count, count_next;
  logic [1:0]                   op_q;
  logic [bsa_pkg::SLOT_W-1:0]   slot_q;
  logic [AW-1:0]                scan_word, scan_word_next;

  // bitmap storage
  logic [bsa_pkg::WORD_W-1:0]   mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]         word_valid;
  logic [AW-1:0]                rd_addr;
  logic [bsa_pkg::WORD_W-1:0]   rd_data;
  logic                         rd_vld;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [bsa_pkg::WORD_W-1:0]   wr_data;

  // result staging
  logic                         res_en;
  logic [bsa_pkg::SLOT_W-1:0]   res_slot;
  logic [bsa_pkg::STATUS_W-1:0] res_status;

  // datapath helpers
  logic [bsa_pkg::CFG_W-1:0]      lim;
  logic [bsa_pkg::CFG_W-1:0]      lim_m1;
  logic [bsa_pkg::WORD_SEL_W-1:0] last_word;
  logic [bsa_pkg::WORD_SEL_W-1:0] scan_word_ext;
  logic [bsa_pkg::WORD_W-1:0]     word_eff;
  logic [bsa_pkg::WORD_W-1:0]     lim_mask;
  logic [bsa_pkg::WORD_W-1:0]     free_vec;
  logic [bsa_pkg::CFG_W-1:0]      grant_full;
  logic [AW-1:0]                  slot_word;
  logic [AW-1:0]                  in_slot_word;
  logic                           slot_bit;
  logic                           slot_in_range;
  bsa_pkg::ff_result_t            ff;

  assign busy      = (state != bsa_pkg::S_IDLE);
  assign cfg_ready = (state == bsa_pkg::S_IDLE);

  // slot limit, saturated to the slot count
  assign lim       = (active_slots > CAP) ? CAP : active_slots;
  assign lim_m1    = lim - bsa_pkg::CFG_W'(1);
  assign last_word = lim_m1[bsa_pkg::CFG_W-1:bsa_pkg::BIT_IDX_W];
  assign scan_word_ext = bsa_pkg::WORD_SEL_W'(scan_word);

  // word holding the requested slot
  assign slot_word    = AW'(slot_q[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_IDX_W]);
  assign in_slot_word = AW'(slot_index[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_IDX_W]);

  // unwritten words read as all free
  assign word_eff      = rd_vld ? rd_data : '0;
  assign slot_bit      = word_eff[slot_q[bsa_pkg::BIT_IDX_W-1:0]];
  assign slot_in_range = ({1'b0, slot_q} < lim);

  // slots of the word being scanned that lie below the limit
  always_comb begin
    if (lim == '0) begin
      lim_mask = '0;
    end else if (scan_word_ext < last_word) begin
      lim_mask = '1;
    end else begin
      lim_mask = (bsa_pkg::WORD_W'(2) << lim_m1[bsa_pkg::BIT_IDX_W-1:0])
                 - bsa_pkg::WORD_W'(1);
    end
  end

  assign free_vec   = ~word_eff & lim_mask;
  assign grant_full = {scan_word_ext, ff.index};

  bsa_find_first u_find_first (
    .vec    (free_vec),
    .result (ff)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bsa_pkg::S_IDLE: begin
        if (start) begin
          state_next = (op == bsa_pkg::OP_ALLOC) ? bsa_pkg::S_SCAN : bsa_pkg::S_ACCESS;
        end
      end
      bsa_pkg::S_SCAN: begin
        if (ff.found || lim == '0 || scan_word_ext == last_word) begin
          state_next = bsa_pkg::S_IDLE;
        end
      end
      bsa_pkg::S_ACCESS: begin
        state_next = bsa_pkg::S_IDLE;
      end
      default: begin
        state_next = bsa_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs: read address, bitmap update, count and result
  always_comb begin
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = scan_word;
    wr_data        = word_eff;
    res_en         = 1'b0;
    res_slot       = slot_q;
    res_status     = bsa_pkg::ST_OK;
    count_next     = count;
    scan_word_next = scan_word;
    case (state)
      bsa_pkg::S_IDLE: begin
        scan_word_next = '0;
        rd_addr        = (op == bsa_pkg::OP_ALLOC) ? '0 : in_slot_word;
      end
      bsa_pkg::S_SCAN: begin
        if (ff.found) begin
          wr_en      = 1'b1;
          wr_data    = word_eff | (bsa_pkg::WORD_W'(1) << ff.index);
          count_next = count + bsa_pkg::CFG_W'(1);
          res_en     = 1'b1;
          res_slot   = grant_full[bsa_pkg::SLOT_W-1:0];
        end else if (lim == '0 || scan_word_ext == last_word) begin
          res_en     = 1'b1;
          res_slot   = '0;
          res_status = bsa_pkg::ST_FULL;
        end else begin
          scan_word_next = scan_word + AW'(1);
          rd_addr        = scan_word + AW'(1);
        end
      end
      bsa_pkg::S_ACCESS: begin
        res_en  = 1'b1;
        wr_addr = slot_word;
        case (op_q)
          bsa_pkg::OP_FREE: begin
            if (slot_q == '0) begin
              res_status = bsa_pkg::ST_ROOT;
            end else if (!slot_in_range) begin
              res_status = bsa_pkg::ST_RANGE;
            end else if (slot_bit) begin
              wr_en      = 1'b1;
              wr_data    = word_eff & ~(bsa_pkg::WORD_W'(1) << slot_q[bsa_pkg::BIT_IDX_W-1:0]);
              count_next = count - bsa_pkg::CFG_W'(1);
            end
          end
          bsa_pkg::OP_CHECK: begin
            if (!slot_in_range) begin
              res_status = bsa_pkg::ST_RANGE;
            end else if (!slot_bit) begin
              res_status = bsa_pkg::ST_FREE;
            end
          end
          default: begin
            res_status = bsa_pkg::ST_RANGE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bsa_pkg::S_IDLE;
      count        <= '0;
      active_slots <= bsa_pkg::ACTIVE_SLOTS_RESET;
      done         <= 1'b0;
      word_valid   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_en;
      if (cfg_valid && cfg_ready) begin
        active_slots <= cfg_data;
      end
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // request capture, scan cursor and result fields
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q   <= op;
      slot_q <= slot_index;
    end
    scan_word <= scan_word_next;
    if (res_en) begin
      granted_slot <= res_slot;
      status       <= res_status;
      live_count   <= count_next;
    end
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= word_valid[rd_addr];
  end

  // a result only follows a cycle of work
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != bsa_pkg::S_IDLE)
    else $error("result strobe without a request in progress");

  // an accepted transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not start the sequencer");

  // occupied count never passes the reachable slot range
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("occupied count beyond slot range");

  // a granted allocation raises the count by one
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    done && op_q == bsa_pkg::OP_ALLOC && status == bsa_pkg::ST_OK
      |-> live_count == bsa_pkg::CFG_W'($past(count) + bsa_pkg::CFG_W'(1)))
    else $error("allocation did not increment occupied count");

endmodule

`default_nettype wire

// ===== design/bsa_find_first.sv =====
// find-first-set unit over one 64-bit bitmap word
`default_nettype none

module bsa_find_first (
  input  wire logic [bsa_pkg::WORD_W-1:0] vec,
  output bsa_pkg::ff_result_t             result
);

  // binary search for the lowest set bit, halving the window at each level
  always_comb begin
    logic [bsa_pkg::WORD_W-1:0]    work;
    logic [bsa_pkg::WORD_W-1:0]    lo_mask;
    logic [bsa_pkg::BIT_IDX_W-1:0] idx;
    work = vec;
    idx  = '0;
    for (int lvl = bsa_pkg::BIT_IDX_W - 1; lvl >= 0; lvl--) begin
      lo_mask = (bsa_pkg::WORD_W'(1) << (1 << lvl)) - bsa_pkg::WORD_W'(1);
      if ((work & lo_mask) == '0) begin
        idx[lvl] = 1'b1;
        work     = work >> (1 << lvl);
      end
    end
    result.found = |vec;
    result.index = idx;
  end

endmodule

`default_nettype wire
